FILE: hw/rtl/arm64_entry_instruction_relocator_defines.svh
// Assertion macros used by the relocator checker.
`ifndef ARM64_ENTRY_INSTRUCTION_RELOCATOR_DEFINES_SVH
`define ARM64_ENTRY_INSTRUCTION_RELOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AEIR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("relocator check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define AEIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("relocator check failed one cycle later");

`endif

FILE: hw/rtl/aeir_pkg.sv
package aeir_pkg;

  // How an instruction is rebuilt in the trampoline body.
  typedef enum logic [1:0] {
    KIND_BRANCH = 2'd0,
    KIND_ADR    = 2'd1,
    KIND_COPY   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] first_word;
    logic [63:0] target;
    logic [63:0] resume;
  } entry_t;

  // Fixed trampoline encodings.
  localparam logic [31:0] LDR_X17_LIT8 = 32'h5800_0051;
  localparam logic [31:0] LDR_LIT8     = 32'h5800_0040;
  localparam logic [31:0] BR_X17       = 32'hD61F_0220;
  localparam logic [31:0] B_PLUS_12    = 32'h1400_0003;

  // Decode masks and match values.
  localparam logic [31:0] ADR_MASK    = 32'h9F00_0000;
  localparam logic [31:0] ADR_MATCH   = 32'h1000_0000;
  localparam logic [31:0] ADRP_MATCH  = 32'h9000_0000;
  localparam logic [31:0] BR26_MASK   = 32'hFC00_0000;
  localparam logic [31:0] B_MATCH     = 32'h1400_0000;
  localparam logic [31:0] BL_MATCH    = 32'h9400_0000;
  localparam logic [31:0] BCOND_MASK  = 32'hFF00_0010;
  localparam logic [31:0] BCOND_MATCH = 32'h5400_0000;
  localparam logic [31:0] CB_MASK     = 32'h7E00_0000;
  localparam logic [31:0] CBZ_MATCH   = 32'h3400_0000;
  localparam logic [31:0] TBZ_MATCH   = 32'h3600_0000;
  localparam logic [31:0] LIT_MASK    = 32'h3B00_0000;
  localparam logic [31:0] LIT_MATCH   = 32'h1800_0000;

  // Index of the final word of the body for each kind.
  function automatic logic [2:0] last_index(kind_t k);
    logic [2:0] idx;
    case (k)
      KIND_BRANCH: idx = 3'd3;
      KIND_ADR:    idx = 3'd7;
      KIND_COPY:   idx = 3'd4;
      KIND_ERROR:  idx = 3'd0;
      default:     idx = 3'd0;
    endcase
    return idx;
  endfunction

endpackage

FILE: hw/rtl/aeir_front.sv
module aeir_front (
  input  logic [31:0]      instruction,
  input  logic [63:0]      source_address,
  output aeir_pkg::entry_t entry
);

  logic        is_b;
  logic        is_adr;
  logic        is_adrp;
  logic        is_pcrel;
  logic [20:0] imm21;
  logic [63:0] base;
  logic [63:0] offset;

  // Decode the instruction class.
  assign is_b    = (instruction & aeir_pkg::BR26_MASK) == aeir_pkg::B_MATCH;
  assign is_adr  = (instruction & aeir_pkg::ADR_MASK) == aeir_pkg::ADR_MATCH;
  assign is_adrp = (instruction & aeir_pkg::ADR_MASK) == aeir_pkg::ADRP_MATCH;
  assign is_pcrel = is_b || is_adr || is_adrp
      || ((instruction & aeir_pkg::BR26_MASK) == aeir_pkg::BL_MATCH)
      || ((instruction & aeir_pkg::BCOND_MASK) == aeir_pkg::BCOND_MATCH)
      || ((instruction & aeir_pkg::CB_MASK) == aeir_pkg::CBZ_MATCH)
      || ((instruction & aeir_pkg::CB_MASK) == aeir_pkg::TBZ_MATCH)
      || ((instruction & aeir_pkg::LIT_MASK) == aeir_pkg::LIT_MATCH);

  assign imm21 = {instruction[23:5], instruction[30:29]};

  // Pick the base and the scaled, sign-extended offset for the one adder.
  always_comb begin
    if (is_b) begin
      base   = source_address;
      offset = {{36{instruction[25]}}, instruction[25:0], 2'b00};
    end else if (is_adrp) begin
      base   = {source_address[63:12], 12'h000};
      offset = {{31{imm21[20]}}, imm21, 12'h000};
    end else begin
      base   = source_address;
      offset = {{43{imm21[20]}}, imm21};
    end
  end

  // Build the queue entry.
  always_comb begin
    entry.target = base + offset;
    entry.resume = source_address + 64'd4;
    if (is_b) begin
      entry.kind       = aeir_pkg::KIND_BRANCH;
      entry.first_word = aeir_pkg::LDR_X17_LIT8;
    end else if (is_adr || is_adrp) begin
      entry.kind       = aeir_pkg::KIND_ADR;
      entry.first_word = aeir_pkg::LDR_LIT8 | {27'd0, instruction[4:0]};
    end else if (!is_pcrel) begin
      entry.kind       = aeir_pkg::KIND_COPY;
      entry.first_word = instruction;
    end else begin
      entry.kind       = aeir_pkg::KIND_ERROR;
      entry.first_word = 32'd0;
    end
  end

endmodule

FILE: hw/rtl/aeir_queue.sv
module aeir_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  aeir_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output aeir_pkg::entry_t head_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  aeir_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_nxt;
  logic [CW-1:0]    count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = count_r == CW'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and count updates with wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: hw/rtl/aeir_back.sv
module aeir_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  aeir_pkg::entry_t head_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word,
  output logic             out_status
);

  logic        out_valid_r;
  logic [31:0] word_r;
  logic [2:0]  index_r;
  logic        last_r;
  logic        status_r;
  logic [2:0]  cnt_r;
  logic [2:0]  cnt_nxt;
  logic [31:0] word_nxt;
  logic        last_nxt;
  logic        status_nxt;
  logic        load;
  logic        take;

  // The output register takes a new word when empty or being drained.
  assign load = !out_valid_r || !out_stall;
  assign take = load && head_valid;
  assign last_nxt   = cnt_r == aeir_pkg::last_index(head_entry.kind);
  assign status_nxt = head_entry.kind == aeir_pkg::KIND_ERROR;
  assign pop  = take && last_nxt;
  assign cnt_nxt = pop ? 3'd0 : cnt_r + 3'd1;

  // Select the body word for the current position.
  always_comb begin
    word_nxt = 32'd0;
    case (head_entry.kind)
      aeir_pkg::KIND_BRANCH: begin
        case (cnt_r)
          3'd0:    word_nxt = aeir_pkg::LDR_X17_LIT8;
          3'd1:    word_nxt = aeir_pkg::BR_X17;
          3'd2:    word_nxt = head_entry.target[31:0];
          default: word_nxt = head_entry.target[63:32];
        endcase
      end
      aeir_pkg::KIND_ADR: begin
        case (cnt_r)
          3'd0:    word_nxt = head_entry.first_word;
          3'd1:    word_nxt = aeir_pkg::B_PLUS_12;
          3'd2:    word_nxt = head_entry.target[31:0];
          3'd3:    word_nxt = head_entry.target[63:32];
          3'd4:    word_nxt = aeir_pkg::LDR_X17_LIT8;
          3'd5:    word_nxt = aeir_pkg::BR_X17;
          3'd6:    word_nxt = head_entry.resume[31:0];
          default: word_nxt = head_entry.resume[63:32];
        endcase
      end
      aeir_pkg::KIND_COPY: begin
        case (cnt_r)
          3'd0:    word_nxt = head_entry.first_word;
          3'd1:    word_nxt = aeir_pkg::LDR_X17_LIT8;
          3'd2:    word_nxt = aeir_pkg::BR_X17;
          3'd3:    word_nxt = head_entry.resume[31:0];
          default: word_nxt = head_entry.resume[63:32];
        endcase
      end
      default: word_nxt = 32'd0;
    endcase
  end

  // Control state: output valid and the position within the body.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= 3'd0;
    end else begin
      if (load) begin
        out_valid_r <= head_valid;
      end
      if (take) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (take) begin
      word_r   <= word_nxt;
      index_r  <= cnt_r;
      last_r   <= last_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word       = word_r;
  assign out_word_index = index_r;
  assign out_last_word  = last_r;
  assign out_status     = status_r;

endmodule

FILE: hw/rtl/arm64_entry_instruction_relocator.sv
// An accepted item goes into the queue; its first word is then loaded into the output register.
// One word per cycle leaves the output register while out_stall is low, so an item gives four words
// for B, eight for ADR or ADRP, five for a copied instruction and one for an unrelocatable one.
// The queue lets the next items be accepted while words are still being sent.
// Reset (rst_n low, synchronous) empties the queue, clears the word counter and out_valid.
module arm64_entry_instruction_relocator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction,
  input  logic [63:0] in_source_address,
  input  logic [63:0] in_trampoline_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_status
);

  aeir_pkg::entry_t front_entry;
  aeir_pkg::entry_t head_entry;
  logic             queue_full;
  logic             head_valid;
  logic             pop;

  // The body uses only PC-relative loads and branches and a register branch, so the trampoline start affects no word.
  aeir_front u_front (
    .instruction    (in_instruction),
    .source_address (in_source_address),
    .entry          (front_entry)
  );

  aeir_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_entry (front_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  aeir_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_entry     (head_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word),
    .out_status     (out_status)
  );

  assign in_stall = queue_full;

endmodule

FILE: hw/rtl/aeir_checker.sv
`include "arm64_entry_instruction_relocator_defines.svh"

module aeir_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word,
  input logic        out_status
);

  logic        mid_take;
  logic        end_take;
  logic [36:0] out_payload;
  logic [2:0]  next_index;
  logic        error_word_ok;
  logic        body_len_ok;

  // Helper terms that keep the checks short.
  assign mid_take      = out_valid && !out_stall && !out_last_word;
  assign end_take      = out_valid && !out_stall && out_last_word;
  assign out_payload   = {out_word, out_word_index, out_last_word, out_status};
  assign next_index    = out_word_index + 3'd1;
  assign error_word_ok = out_last_word && (out_word == 32'd0) && (out_word_index == 3'd0);
  assign body_len_ok   = (out_word_index == 3'd3) || (out_word_index == 3'd4)
      || (out_word_index == 3'd7);

  // A stalled word stays on the port unchanged.
  `AEIR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_payload))

  // An error item is a single zero word.
  `AEIR_ASSERT_NOW(a_error_shape, clk, rst_n, out_valid && out_status, error_word_ok)

  // Words within an item come in consecutive positions.
  `AEIR_ASSERT_NEXT(a_index_step, clk, rst_n, mid_take, !out_valid || out_word_index == $past(next_index))

  // A new item starts at position zero.
  `AEIR_ASSERT_NEXT(a_index_restart, clk, rst_n, end_take, !out_valid || out_word_index == 3'd0)

  // A relocated body ends after four, five or eight words.
  `AEIR_ASSERT_NOW(a_body_length, clk, rst_n, out_valid && out_last_word && !out_status, body_len_ok)

endmodule

bind arm64_entry_instruction_relocator aeir_checker u_checker (.*);
